[rtl/dsfe_pkg.sv]
// shared types and control codes of the dle stuffed frame encoder
package dsfe_pkg;

    localparam logic [7:0] CODE_DLE = 8'h10;
    localparam logic [7:0] CODE_STX = 8'h02;
    localparam logic [7:0] CODE_ETX = 8'h03;

    // output slots of one request, in line order
    localparam int NUM_SLOTS     = 7;
    localparam int SLOT_HDR_DLE  = 0;
    localparam int SLOT_HDR_STX  = 1;
    localparam int SLOT_STUF_DLE = 2;
    localparam int SLOT_DATA     = 3;
    localparam int SLOT_TRL_DLE  = 4;
    localparam int SLOT_TRL_ETX  = 5;
    localparam int SLOT_CHECK    = 6;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // pending request held between the front and the emitter
    typedef struct packed {
        slot_mask_t  mask;
        logic [7:0]  data;
        logic [7:0]  check;
    } pend_t;

    // emitter feedback to the front
    typedef struct packed {
        logic        advance;
        slot_mask_t  clear;
    } step_t;

endpackage

[rtl/dsfe_if.sv]
// valid/ready stream interfaces for input requests and line bytes
interface dsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output first_byte,
                    output last_byte, input ready);
    modport sink (input valid, input payload_byte, input first_byte,
                  input last_byte, output ready);
endinterface

interface dsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, output line_byte, output run_end,
                    output frame_end, input ready);
    modport sink (input valid, input line_byte, input run_end,
                  input frame_end, output ready);
endinterface

[rtl/dle_stuffed_frame_encoder.sv]
// top level of the dle stuffed frame encoder
// Each input request (a payload byte marked first and/or last of its packet) turns into one
// to seven line bytes: DLE STX before a first byte, an extra DLE before a payload DLE, the
// byte itself, and DLE ETX plus the xor check byte after a last byte. The output port moves
// one line byte per cycle unless ready holds it back; a plain byte gives one line byte, a DLE
// two, and a single-byte packet of DLE seven. A new request is taken in the same cycle
// that the last byte of the previous one leaves the pending slot register, and the output
// register lets the next request be taken into the pending slots while a line byte waits.
// The check covers one copy of each payload byte and ETX, and restarts at every first
// byte, even if the previous packet was never closed.
module dle_stuffed_frame_encoder
    import dsfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dsfe_in_if.sink     in,
    dsfe_out_if.source  out
);

    pend_t pend;
    step_t step;

    // input register, slot mask and check accumulator
    dsfe_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in),
        .step  (step),
        .pend  (pend)
    );

    // slot sequencing and output register
    dsfe_emitter u_emitter (
        .clk   (clk),
        .rst_n (rst_n),
        .pend  (pend),
        .step  (step),
        .out   (out)
    );

    // the check byte always closes its request
    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.frame_end |-> out.run_end)
        else $error("frame end without run end");

    // an accepted request always leaves work pending
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in.valid && in.ready |=> pend.mask != '0)
        else $error("accepted request left no pending slots");

    // only one slot leaves per cycle
    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(step.clear))
        else $error("more than one slot picked");

    // pending slots hold while the output is stalled
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend.mask != '0 && !step.advance |=> $stable(pend.mask))
        else $error("pending slots changed during stall");

endmodule

[rtl/dsfe_front.sv]
// input register, slot planning and running xor check
module dsfe_front
    import dsfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dsfe_in_if.sink     in,
    input  step_t       step,
    output pend_t       pend
);

    slot_mask_t mask_reg;
    slot_mask_t mask_next;
    logic [7:0] data_reg;
    logic [7:0] check_reg;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] acc_fold;
    slot_mask_t mask_left;
    slot_mask_t mask_new;
    logic       accept;

    assign mask_left = step.advance ? (mask_reg & ~step.clear) : mask_reg;
    assign in.ready  = (mask_left == '0);
    assign accept    = in.valid && in.ready;

    // fresh check on a first byte
    assign acc_fold = (in.first_byte ? 8'h00 : acc_reg) ^ in.payload_byte;

    always_comb
    begin
        mask_new                = '0;
        mask_new[SLOT_HDR_DLE]  = in.first_byte;
        mask_new[SLOT_HDR_STX]  = in.first_byte;
        mask_new[SLOT_STUF_DLE] = (in.payload_byte == CODE_DLE);
        mask_new[SLOT_DATA]     = 1'b1;
        mask_new[SLOT_TRL_DLE]  = in.last_byte;
        mask_new[SLOT_TRL_ETX]  = in.last_byte;
        mask_new[SLOT_CHECK]    = in.last_byte;
    end

    assign mask_next = accept ? mask_new : mask_left;
    assign acc_next  = accept ? (in.last_byte ? 8'h00 : acc_fold) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= in.payload_byte;
            check_reg <= acc_fold ^ CODE_ETX;
        end
    end

    assign pend.mask  = mask_reg;
    assign pend.data  = data_reg;
    assign pend.check = check_reg;

endmodule

[rtl/dsfe_emitter.sv]
// picks the next slot and drives the output register
module dsfe_emitter
    import dsfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pend_t       pend,
    output step_t       step,
    dsfe_out_if.source  out
);

    slot_mask_t pick;
    logic       load;
    logic [7:0] byte_sel;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] line_reg;
    logic       run_end_reg;
    logic       frame_end_reg;

    // lowest pending slot goes first
    assign pick = pend.mask & (~pend.mask + slot_mask_t'(1'b1));
    assign load = !valid_reg || out.ready;

    assign step.advance = load && (pend.mask != '0);
    assign step.clear   = pick;

    always_comb
    begin
        byte_sel = pend.data;
        if (pick[SLOT_HDR_DLE] || pick[SLOT_STUF_DLE] || pick[SLOT_TRL_DLE])
            byte_sel = CODE_DLE;
        else if (pick[SLOT_HDR_STX])
            byte_sel = CODE_STX;
        else if (pick[SLOT_TRL_ETX])
            byte_sel = CODE_ETX;
        else if (pick[SLOT_CHECK])
            byte_sel = pend.check;
    end

    assign valid_next = load ? (pend.mask != '0) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step.advance)
        begin
            line_reg      <= byte_sel;
            run_end_reg   <= ((pend.mask & ~pick) == '0);
            frame_end_reg <= pick[SLOT_CHECK];
        end
    end

    assign out.valid     = valid_reg;
    assign out.line_byte = line_reg;
    assign out.run_end   = run_end_reg;
    assign out.frame_end = frame_end_reg;

endmodule
